FILE: src/sa_lcp_pkg.sv
// Shared types and constants of the suffix array / LCP builder.
// Used by the controller, the datapath, the top level and the testbench.
// Depends on nothing.
package sa_lcp_pkg;

  localparam int MAX_TEXT  = 63;   // bytes kept per text
  localparam int IDX_W     = 6;    // position / rank index
  localparam int LEN_W     = 7;    // length, holds 64
  localparam int CNT_AW    = 9;    // bucket address, covers 257 byte keys
  localparam int KEY_W     = 9;    // byte key plus sentinel, or class
  localparam int BYTE_KEYS = 257;  // sentinel plus 256 byte values

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE, S_INIT_RD, S_INIT_WR, S_CLR,
    S_HIST_RD, S_HIST_CNT, S_HIST_WR,
    S_PFX_RD, S_PFX_WR,
    S_SCT_RD, S_SCT_CLS, S_SCT_CNT, S_SCT_WR,
    S_CLS_RD, S_CLS_A, S_CLS_B, S_CLS_WR,
    S_RANK_RD, S_RANK_WR,
    S_KAS_RD, S_KAS_PRED, S_KAS_TA, S_KAS_TB, S_KAS_CMP,
    S_OUT_RD, S_OUT_SHOW
  } sa_state_t;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT_RD, OP_INIT_WR, OP_CLR,
    OP_HIST_RD, OP_HIST_CNT, OP_HIST_WR,
    OP_PFX_RD, OP_PFX_WR,
    OP_SCT_RD, OP_SCT_CLS, OP_SCT_CNT, OP_SCT_WR,
    OP_CLS_RD, OP_CLS_A, OP_CLS_B, OP_CLS_WR,
    OP_RANK_RD, OP_RANK_WR,
    OP_KAS_RD, OP_KAS_PRED, OP_KAS_TA, OP_KAS_TB, OP_KAS_CMP,
    OP_OUT_RD, OP_OUT_SHOW
  } sa_op_t;

  typedef struct packed {
    sa_op_t op;
    logic   step;    // element finished: advance the pass index
  } sa_cmd_t;

  typedef struct packed {
    logic last;        // pass index is at its final element
    logic round_done;  // next doubling step reaches the text length
    logic r_zero;      // current position holds rank zero
    logic cont;        // common prefix extends by one more symbol
  } sa_status_t;

endpackage

FILE: src/sa_lcp_if.sv
// Valid/ready channel interfaces for text bytes and result entries.
// Depend on nothing beyond the field widths of the block.
interface sa_lcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_text;

  modport source (output valid, output symbol, output end_of_text, input ready);
  modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

interface sa_lcp_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] suffix_start;
  logic [5:0] common_prefix;
  logic       final_entry;

  modport source (output valid, output suffix_start, output common_prefix,
                  output final_entry, input ready);
  modport sink   (input valid, input suffix_start, input common_prefix,
                  input final_entry, output ready);
endinterface

FILE: src/sa_lcp_ctrl.sv
// Sequencer of the suffix array builder: load, prefix-doubling rounds,
// Kasai pass and result readout. Uses sa_lcp_pkg.
module sa_lcp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   end_of_text,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  sa_lcp_pkg::sa_status_t status,
  output sa_lcp_pkg::sa_cmd_t    cmd
);

  sa_lcp_pkg::sa_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sa_lcp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sa_lcp_pkg::S_IDLE:
        if (in_valid && end_of_text) state_next = sa_lcp_pkg::S_INIT_RD;
      sa_lcp_pkg::S_INIT_RD:  state_next = sa_lcp_pkg::S_INIT_WR;
      sa_lcp_pkg::S_INIT_WR:
        state_next = status.last ? sa_lcp_pkg::S_CLR : sa_lcp_pkg::S_INIT_RD;
      sa_lcp_pkg::S_CLR:
        if (status.last) state_next = sa_lcp_pkg::S_HIST_RD;
      sa_lcp_pkg::S_HIST_RD:  state_next = sa_lcp_pkg::S_HIST_CNT;
      sa_lcp_pkg::S_HIST_CNT: state_next = sa_lcp_pkg::S_HIST_WR;
      sa_lcp_pkg::S_HIST_WR:
        state_next = status.last ? sa_lcp_pkg::S_PFX_RD : sa_lcp_pkg::S_HIST_RD;
      sa_lcp_pkg::S_PFX_RD:   state_next = sa_lcp_pkg::S_PFX_WR;
      sa_lcp_pkg::S_PFX_WR:
        state_next = status.last ? sa_lcp_pkg::S_SCT_RD : sa_lcp_pkg::S_PFX_RD;
      sa_lcp_pkg::S_SCT_RD:   state_next = sa_lcp_pkg::S_SCT_CLS;
      sa_lcp_pkg::S_SCT_CLS:  state_next = sa_lcp_pkg::S_SCT_CNT;
      sa_lcp_pkg::S_SCT_CNT:  state_next = sa_lcp_pkg::S_SCT_WR;
      sa_lcp_pkg::S_SCT_WR:
        state_next = status.last ? sa_lcp_pkg::S_CLS_RD : sa_lcp_pkg::S_SCT_RD;
      sa_lcp_pkg::S_CLS_RD:   state_next = sa_lcp_pkg::S_CLS_A;
      sa_lcp_pkg::S_CLS_A:    state_next = sa_lcp_pkg::S_CLS_B;
      sa_lcp_pkg::S_CLS_B:    state_next = sa_lcp_pkg::S_CLS_WR;
      sa_lcp_pkg::S_CLS_WR:
        if (!status.last)          state_next = sa_lcp_pkg::S_CLS_RD;
        else if (status.round_done) state_next = sa_lcp_pkg::S_RANK_RD;
        else                        state_next = sa_lcp_pkg::S_CLR;
      sa_lcp_pkg::S_RANK_RD:  state_next = sa_lcp_pkg::S_RANK_WR;
      sa_lcp_pkg::S_RANK_WR:
        state_next = status.last ? sa_lcp_pkg::S_KAS_RD : sa_lcp_pkg::S_RANK_RD;
      sa_lcp_pkg::S_KAS_RD:   state_next = sa_lcp_pkg::S_KAS_PRED;
      sa_lcp_pkg::S_KAS_PRED:
        if (!status.r_zero)   state_next = sa_lcp_pkg::S_KAS_TA;
        else if (status.last) state_next = sa_lcp_pkg::S_OUT_RD;
        else                  state_next = sa_lcp_pkg::S_KAS_RD;
      sa_lcp_pkg::S_KAS_TA:   state_next = sa_lcp_pkg::S_KAS_TB;
      sa_lcp_pkg::S_KAS_TB:   state_next = sa_lcp_pkg::S_KAS_CMP;
      sa_lcp_pkg::S_KAS_CMP:
        if (status.cont)      state_next = sa_lcp_pkg::S_KAS_TA;
        else if (status.last) state_next = sa_lcp_pkg::S_OUT_RD;
        else                  state_next = sa_lcp_pkg::S_KAS_RD;
      sa_lcp_pkg::S_OUT_RD:   state_next = sa_lcp_pkg::S_OUT_SHOW;
      sa_lcp_pkg::S_OUT_SHOW:
        if (out_ready) begin
          state_next = status.last ? sa_lcp_pkg::S_IDLE : sa_lcp_pkg::S_OUT_RD;
        end
      default: state_next = sa_lcp_pkg::S_IDLE;
    endcase
  end

  // Outputs: one datapath operation per state
  always_comb begin
    cmd       = '{op: sa_lcp_pkg::OP_NONE, step: 1'b0};
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      sa_lcp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = sa_lcp_pkg::OP_LOAD;
      end
      sa_lcp_pkg::S_INIT_RD:  cmd.op = sa_lcp_pkg::OP_INIT_RD;
      sa_lcp_pkg::S_INIT_WR:  cmd = '{op: sa_lcp_pkg::OP_INIT_WR, step: 1'b1};
      sa_lcp_pkg::S_CLR:      cmd = '{op: sa_lcp_pkg::OP_CLR, step: 1'b1};
      sa_lcp_pkg::S_HIST_RD:  cmd.op = sa_lcp_pkg::OP_HIST_RD;
      sa_lcp_pkg::S_HIST_CNT: cmd.op = sa_lcp_pkg::OP_HIST_CNT;
      sa_lcp_pkg::S_HIST_WR:  cmd = '{op: sa_lcp_pkg::OP_HIST_WR, step: 1'b1};
      sa_lcp_pkg::S_PFX_RD:   cmd.op = sa_lcp_pkg::OP_PFX_RD;
      sa_lcp_pkg::S_PFX_WR:   cmd = '{op: sa_lcp_pkg::OP_PFX_WR, step: 1'b1};
      sa_lcp_pkg::S_SCT_RD:   cmd.op = sa_lcp_pkg::OP_SCT_RD;
      sa_lcp_pkg::S_SCT_CLS:  cmd.op = sa_lcp_pkg::OP_SCT_CLS;
      sa_lcp_pkg::S_SCT_CNT:  cmd.op = sa_lcp_pkg::OP_SCT_CNT;
      sa_lcp_pkg::S_SCT_WR:   cmd = '{op: sa_lcp_pkg::OP_SCT_WR, step: 1'b1};
      sa_lcp_pkg::S_CLS_RD:   cmd.op = sa_lcp_pkg::OP_CLS_RD;
      sa_lcp_pkg::S_CLS_A:    cmd.op = sa_lcp_pkg::OP_CLS_A;
      sa_lcp_pkg::S_CLS_B:    cmd.op = sa_lcp_pkg::OP_CLS_B;
      sa_lcp_pkg::S_CLS_WR:   cmd = '{op: sa_lcp_pkg::OP_CLS_WR, step: 1'b1};
      sa_lcp_pkg::S_RANK_RD:  cmd.op = sa_lcp_pkg::OP_RANK_RD;
      sa_lcp_pkg::S_RANK_WR:  cmd = '{op: sa_lcp_pkg::OP_RANK_WR, step: 1'b1};
      sa_lcp_pkg::S_KAS_RD:   cmd.op = sa_lcp_pkg::OP_KAS_RD;
      sa_lcp_pkg::S_KAS_PRED:
        cmd = '{op: sa_lcp_pkg::OP_KAS_PRED, step: status.r_zero};
      sa_lcp_pkg::S_KAS_TA:   cmd.op = sa_lcp_pkg::OP_KAS_TA;
      sa_lcp_pkg::S_KAS_TB:   cmd.op = sa_lcp_pkg::OP_KAS_TB;
      sa_lcp_pkg::S_KAS_CMP:
        cmd = '{op: sa_lcp_pkg::OP_KAS_CMP, step: !status.cont};
      sa_lcp_pkg::S_OUT_RD:   cmd.op = sa_lcp_pkg::OP_OUT_RD;
      sa_lcp_pkg::S_OUT_SHOW: begin
        out_valid = 1'b1;
        cmd       = '{op: sa_lcp_pkg::OP_OUT_SHOW, step: out_ready};
      end
      default: cmd.op = sa_lcp_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: src/sa_lcp_dp.sv
// Datapath of the suffix array builder: text, order, class, bucket,
// rank and LCP memories with their index registers and compares.
// Uses sa_lcp_pkg; driven by sa_lcp_ctrl commands.
module sa_lcp_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  sa_lcp_pkg::sa_cmd_t    cmd,
  output sa_lcp_pkg::sa_status_t status,
  input  logic [7:0]             symbol,
  input  logic                   end_of_text,
  output logic [5:0]             suffix_start,
  output logic [5:0]             common_prefix,
  output logic                   final_entry
);

  localparam int IW = sa_lcp_pkg::IDX_W;
  localparam int LW = sa_lcp_pkg::LEN_W;
  localparam int KW = sa_lcp_pkg::KEY_W;
  localparam int CW = sa_lcp_pkg::CNT_AW;

  // Fold x into 0..m-1 where x < 2m
  function automatic logic [IW-1:0] wrap_idx(input logic [LW:0] x, input logic [LW-1:0] m);
    logic [LW:0] d;
    d = x - {1'b0, m};
    wrap_idx = (x >= {1'b0, m}) ? d[IW-1:0] : x[IW-1:0];
  endfunction

  // Sort key: sentinel lowest, then bytes in unsigned order
  function automatic logic [KW-1:0] key_of(input logic [7:0] b, input logic sentinel);
    key_of = sentinel ? '0 : ({1'b0, b} + KW'(1));
  endfunction

  // Memories
  logic [7:0]    text_mem  [2**IW];
  logic [IW-1:0] order_mem [2**IW];
  logic [IW-1:0] scr_mem   [2**IW];
  logic [KW-1:0] cls0_mem  [2**IW];
  logic [KW-1:0] cls1_mem  [2**IW];
  logic [LW-1:0] cnt_mem   [2**CW];
  logic [IW-1:0] rank_mem  [2**IW];
  logic [IW-1:0] lcp_mem   [2**IW];

  // Control and working registers
  logic [LW-1:0] len, n, k, acc, l;
  logic [CW-1:0] i;
  logic          bank, range_big, q_sent;
  logic [IW-1:0] p, a;
  logic [KW-1:0] ca, prev_ca, prev_cb, prev_new, key_a;

  // Registered read data
  logic [7:0]    text_rd;
  logic [IW-1:0] ord_rd, scr_rd, rank_rd, lcp_rd;
  logic [KW-1:0] cls0_rd, cls1_rd, cls_rd;
  logic [LW-1:0] cnt_rd;

  // Port controls
  logic          text_we, text_re, ord_we, ord_re, scr_we, scr_re;
  logic          cls_we, cls_wsel, cls_re, cnt_we, cnt_re;
  logic          rank_we, rank_re, lcp_we, lcp_re;
  logic [IW-1:0] text_wa, text_ra, ord_wa, ord_wd, ord_ra, scr_wa, scr_ra;
  logic [IW-1:0] cls_wa, cls_ra, rank_wa, rank_wd, rank_ra, lcp_wa, lcp_wd;
  logic [KW-1:0] cls_wd;
  logic [CW-1:0] cnt_wa, cnt_ra;
  logic [LW-1:0] cnt_wd;

  // Derived values
  logic [CW-1:0] limit_m1;
  logic [LW-1:0] k_next, len_after, l_fin;
  logic [IW-1:0] p_now, qa, qb, ab_idx;
  logic [KW-1:0] new_cls;
  logic          differ, key_eq, last;

  assign cls_rd = bank ? cls1_rd : cls0_rd;

  // Final index of the current pass
  always_comb begin
    unique case (cmd.op) inside
      sa_lcp_pkg::OP_CLR, sa_lcp_pkg::OP_PFX_RD, sa_lcp_pkg::OP_PFX_WR:
        limit_m1 = range_big ? CW'(sa_lcp_pkg::BYTE_KEYS - 1) : (CW'(n) - CW'(1));
      sa_lcp_pkg::OP_KAS_RD, sa_lcp_pkg::OP_KAS_PRED, sa_lcp_pkg::OP_KAS_TA,
      sa_lcp_pkg::OP_KAS_TB, sa_lcp_pkg::OP_KAS_CMP:
        limit_m1 = CW'(n) - CW'(2);
      default:
        limit_m1 = CW'(n) - CW'(1);
    endcase
  end

  assign last      = (i == limit_m1);
  assign k_next    = (k == '0) ? LW'(1) : {k[LW-2:0], 1'b0};
  assign len_after = (len < LW'(sa_lcp_pkg::MAX_TEXT)) ? len + LW'(1) : len;
  assign p_now     = wrap_idx({2'b0, ord_rd} + {1'b0, n} - {1'b0, k}, n);
  assign ab_idx    = wrap_idx({2'b0, a} + {1'b0, k}, n);
  assign qa        = wrap_idx({2'b0, i[IW-1:0]} + {1'b0, l}, n);
  assign qb        = wrap_idx({2'b0, ord_rd} + {1'b0, l}, n);
  assign differ    = (ca != prev_ca) || (cls_rd != prev_cb);
  assign new_cls   = (i == '0) ? '0 : (prev_new + KW'(differ));
  assign key_eq    = (key_a == key_of(text_rd, q_sent));
  assign l_fin     = key_eq ? l + LW'(1) : l;

  assign status.last       = last;
  assign status.round_done = (k_next >= n);
  assign status.r_zero     = (rank_rd == '0);
  assign status.cont       = key_eq && ((l + LW'(1)) < n);

  // Memory port selection
  always_comb begin
    text_we = 1'b0; text_wa = len[IW-1:0]; text_re = 1'b0; text_ra = i[IW-1:0];
    ord_we  = 1'b0; ord_wa  = i[IW-1:0];   ord_wd  = i[IW-1:0];
    ord_re  = 1'b0; ord_ra  = i[IW-1:0];
    scr_we  = 1'b0; scr_wa  = cnt_rd[IW-1:0]; scr_re = 1'b0; scr_ra = i[IW-1:0];
    cls_we  = 1'b0; cls_wsel = bank; cls_wa = i[IW-1:0];
    cls_wd  = key_of(text_rd, CW'(n) - CW'(1) == i);
    cls_re  = 1'b0; cls_ra = i[IW-1:0];
    cnt_we  = 1'b0; cnt_wa = i; cnt_wd = '0; cnt_re = 1'b0; cnt_ra = i;
    rank_we = 1'b0; rank_wa = ord_rd; rank_wd = i[IW-1:0];
    rank_re = 1'b0; rank_ra = i[IW-1:0];
    lcp_we  = 1'b0; lcp_wa = rank_rd; lcp_wd = l_fin[IW-1:0];
    lcp_re  = 1'b0;
    case (cmd.op)
      sa_lcp_pkg::OP_LOAD:     text_we = (len < LW'(sa_lcp_pkg::MAX_TEXT));
      sa_lcp_pkg::OP_INIT_RD:  text_re = 1'b1;
      sa_lcp_pkg::OP_INIT_WR: begin
        cls_we = 1'b1;
        ord_we = 1'b1;
      end
      sa_lcp_pkg::OP_CLR:      cnt_we = 1'b1;
      sa_lcp_pkg::OP_HIST_RD:  cls_re = 1'b1;
      sa_lcp_pkg::OP_HIST_CNT: begin
        cnt_re = 1'b1;
        cnt_ra = cls_rd;
      end
      sa_lcp_pkg::OP_HIST_WR: begin
        cnt_we = 1'b1;
        cnt_wa = cls_rd;
        cnt_wd = cnt_rd + LW'(1);
      end
      sa_lcp_pkg::OP_PFX_RD:   cnt_re = 1'b1;
      sa_lcp_pkg::OP_PFX_WR: begin
        cnt_we = 1'b1;
        cnt_wd = acc;
      end
      sa_lcp_pkg::OP_SCT_RD:   ord_re = 1'b1;
      sa_lcp_pkg::OP_SCT_CLS: begin
        cls_re = 1'b1;
        cls_ra = p_now;
      end
      sa_lcp_pkg::OP_SCT_CNT: begin
        cnt_re = 1'b1;
        cnt_ra = cls_rd;
      end
      sa_lcp_pkg::OP_SCT_WR: begin
        scr_we = 1'b1;
        cnt_we = 1'b1;
        cnt_wa = cls_rd;
        cnt_wd = cnt_rd + LW'(1);
      end
      sa_lcp_pkg::OP_CLS_RD:   scr_re = 1'b1;
      sa_lcp_pkg::OP_CLS_A: begin
        ord_we = 1'b1;
        ord_wd = scr_rd;
        cls_re = 1'b1;
        cls_ra = scr_rd;
      end
      sa_lcp_pkg::OP_CLS_B: begin
        cls_re = 1'b1;
        cls_ra = ab_idx;
      end
      sa_lcp_pkg::OP_CLS_WR: begin
        cls_we   = 1'b1;
        cls_wsel = !bank;
        cls_wa   = a;
        cls_wd   = new_cls;
      end
      sa_lcp_pkg::OP_RANK_RD:  ord_re = 1'b1;
      sa_lcp_pkg::OP_RANK_WR:  rank_we = 1'b1;
      sa_lcp_pkg::OP_KAS_RD:   rank_re = 1'b1;
      sa_lcp_pkg::OP_KAS_PRED: begin
        ord_re = !status.r_zero;
        ord_ra = rank_rd - IW'(1);
      end
      sa_lcp_pkg::OP_KAS_TA: begin
        text_re = 1'b1;
        text_ra = qa;
      end
      sa_lcp_pkg::OP_KAS_TB: begin
        text_re = 1'b1;
        text_ra = qb;
      end
      sa_lcp_pkg::OP_KAS_CMP:  lcp_we = !status.cont;
      sa_lcp_pkg::OP_OUT_RD: begin
        ord_re = 1'b1;
        lcp_re = 1'b1;
      end
      default: ;
    endcase
  end

  // Memory arrays: one write and one registered read each
  always_ff @(posedge clk) begin
    if (text_we) text_mem[text_wa] <= symbol;
    if (text_re) text_rd <= text_mem[text_ra];
  end

  always_ff @(posedge clk) begin
    if (ord_we) order_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_rd <= order_mem[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_wa] <= p;
    if (scr_re) scr_rd <= scr_mem[scr_ra];
  end

  always_ff @(posedge clk) begin
    if (cls_we && !cls_wsel) cls0_mem[cls_wa] <= cls_wd;
    if (cls_re) cls0_rd <= cls0_mem[cls_ra];
  end

  always_ff @(posedge clk) begin
    if (cls_we && cls_wsel) cls1_mem[cls_wa] <= cls_wd;
    if (cls_re) cls1_rd <= cls1_mem[cls_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    if (rank_re) rank_rd <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk) begin
    if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
    if (lcp_re) lcp_rd <= lcp_mem[i[IW-1:0]];
  end

  // Control registers: length, pass index, doubling step, class bank
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      n         <= '0;
      i         <= '0;
      k         <= '0;
      bank      <= 1'b0;
      range_big <= 1'b1;
    end else begin
      if (cmd.step) i <= last ? '0 : i + CW'(1);
      if (cmd.op == sa_lcp_pkg::OP_LOAD) begin
        if (end_of_text) begin
          n         <= len_after + LW'(1);
          len       <= '0;
          k         <= '0;
          bank      <= 1'b0;
          range_big <= 1'b1;
        end else begin
          len <= len_after;
        end
      end
      if (cmd.op == sa_lcp_pkg::OP_CLS_WR && last) begin
        bank      <= !bank;
        k         <= k_next;
        range_big <= 1'b0;
      end
    end
  end

  // Working registers of the sort and LCP passes
  always_ff @(posedge clk) begin
    case (cmd.op)
      sa_lcp_pkg::OP_LOAD:     l <= '0;
      sa_lcp_pkg::OP_CLR:      acc <= '0;
      sa_lcp_pkg::OP_PFX_WR:   acc <= acc + cnt_rd;
      sa_lcp_pkg::OP_SCT_CLS:  p <= p_now;
      sa_lcp_pkg::OP_CLS_A:    a <= scr_rd;
      sa_lcp_pkg::OP_CLS_B:    ca <= cls_rd;
      sa_lcp_pkg::OP_CLS_WR: begin
        prev_ca  <= ca;
        prev_cb  <= cls_rd;
        prev_new <= new_cls;
      end
      sa_lcp_pkg::OP_KAS_PRED: if (status.r_zero) l <= '0;
      sa_lcp_pkg::OP_KAS_TA:   q_sent <= ({1'b0, qa} == n - LW'(1));
      sa_lcp_pkg::OP_KAS_TB: begin
        key_a  <= key_of(text_rd, q_sent);
        q_sent <= ({1'b0, qb} == n - LW'(1));
      end
      sa_lcp_pkg::OP_KAS_CMP: begin
        if (status.cont) l <= l + LW'(1);
        else             l <= (l_fin != '0) ? l_fin - LW'(1) : '0;
      end
      default: ;
    endcase
  end

  // Result fields, held while the entry waits
  assign suffix_start  = ord_rd;
  assign common_prefix = (i == '0) ? '0 : lcp_rd;
  assign final_entry   = last;

endmodule

FILE: src/suffix_array_with_lcp.sv
// Top level of the suffix array / LCP builder: controller plus datapath.
// Uses sa_lcp_pkg, sa_lcp_if, sa_lcp_ctrl and sa_lcp_dp.
//
//   channel     dir  payload                                    transaction
//   text_in     in   symbol[7:0], end_of_text                   valid && ready
//   result_out  out  suffix_start[5:0], common_prefix[5:0],     valid && ready
//                    final_entry
//
// text_in stays ready while bytes without end_of_text arrive. After the
// flagged byte the build runs its sorting and Kasai passes; results then
// leave one at a time, each read and then shown until taken. text_in is
// held off from the flagged byte until the final entry is taken. Reset is
// synchronous; a stalled result holds its fields until taken.
module suffix_array_with_lcp (
  input  logic                clk,
  input  logic                rst,
  sa_lcp_in_if.sink           text_in,
  sa_lcp_out_if.source        result_out
);

  sa_lcp_pkg::sa_cmd_t    cmd;
  sa_lcp_pkg::sa_status_t status;

  sa_lcp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (text_in.valid),
    .end_of_text (text_in.end_of_text),
    .in_ready    (text_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .status      (status),
    .cmd         (cmd)
  );

  sa_lcp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .symbol        (text_in.symbol),
    .end_of_text   (text_in.end_of_text),
    .suffix_start  (result_out.suffix_start),
    .common_prefix (result_out.common_prefix),
    .final_entry   (result_out.final_entry)
  );

endmodule

FILE: dv/suffix_array_with_lcp_test.sv
// Testbench of the suffix array / LCP builder: drives texts byte by byte and
// checks every (suffix start, common prefix, final) entry against a predictor.
// Depends on sa_lcp_pkg, sa_lcp_if and the top level suffix_array_with_lcp.
`timescale 1ns / 1ps

module suffix_array_with_lcp_test;

  typedef struct packed {
    logic [5:0] suffix_start;
    logic [5:0] common_prefix;
    logic       final_entry;
  } entry_t;

  logic clk;
  logic rst;

  sa_lcp_in_if  text_in ();
  sa_lcp_out_if result_out ();

  suffix_array_with_lcp i_dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in.sink),
    .result_out (result_out.source)
  );

  // Predictor state
  logic [7:0] stored_text[sa_lcp_pkg::MAX_TEXT];
  int         stored_len;
  entry_t     expected_entries[$];

  int mismatches;
  int send_idle_pct;
  int take_idle_pct;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("suffix_array_with_lcp_test NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Sort cyclic shifts by doubling, then Kasai; queue expected entries
  task automatic predict_table();
    int n, k, i, acc, a, b, l, r, j;
    int key[64], ord[64], cls[64], tmp[64], cnt[257], rnk[64], lcp[64];
    entry_t e;
    n = stored_len + 1;
    for (i = 0; i < n; i++) key[i] = (i + 1 < n) ? stored_text[i] + 1 : 0;
    for (i = 0; i < 257; i++) cnt[i] = 0;
    for (i = 0; i < n; i++) cnt[key[i]]++;
    acc = 0;
    for (i = 0; i < 257; i++) begin
      a = cnt[i]; cnt[i] = acc; acc += a;
    end
    for (i = 0; i < n; i++) begin
      ord[cnt[key[i]]] = i; cnt[key[i]]++;
    end
    cls[ord[0]] = 0;
    for (i = 1; i < n; i++)
      cls[ord[i]] = cls[ord[i-1]] + (key[ord[i]] != key[ord[i-1]]);
    for (k = 1; k < n; k <<= 1) begin
      for (i = 0; i < n; i++) ord[i] = (ord[i] + n - k) % n;
      for (i = 0; i < n; i++) cnt[i] = 0;
      for (i = 0; i < n; i++) cnt[cls[i]]++;
      acc = 0;
      for (i = 0; i < n; i++) begin
        a = cnt[i]; cnt[i] = acc; acc += a;
      end
      for (i = 0; i < n; i++) begin
        tmp[cnt[cls[ord[i]]]] = ord[i]; cnt[cls[ord[i]]]++;
      end
      for (i = 0; i < n; i++) ord[i] = tmp[i];
      tmp[ord[0]] = 0;
      for (i = 1; i < n; i++) begin
        a = ord[i]; b = ord[i-1];
        tmp[a] = tmp[b] + (cls[a] != cls[b] || cls[(a+k)%n] != cls[(b+k)%n]);
      end
      for (i = 0; i < n; i++) cls[i] = tmp[i];
    end
    for (i = 0; i < n; i++) rnk[ord[i]] = i;
    lcp[0] = 0;
    l = 0;
    for (i = 0; i + 1 < n; i++) begin
      r = rnk[i];
      if (r == 0) begin
        l = 0;
      end else begin
        j = ord[r-1];
        while (l < n && key[(i+l)%n] == key[(j+l)%n]) l++;
        lcp[r] = l;
        if (l > 0) l--;
      end
    end
    for (r = 0; r < n; r++) begin
      e.suffix_start  = 6'(ord[r]);
      e.common_prefix = (r == 0) ? 6'd0 : 6'(lcp[r]);
      e.final_entry   = (r + 1 == n);
      expected_entries = {expected_entries, e};
    end
    stored_len = 0;
  endtask

  // Offer one byte, hold until the transaction, then update the predictor;
  // drop valid only while the sender idles
  task automatic send_symbol(input logic [7:0] sym, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      text_in.valid <= 1'b0;
      @(negedge clk);
    end
    text_in.valid       <= 1'b1;
    text_in.symbol      <= sym;
    text_in.end_of_text <= eot;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    if (stored_len < sa_lcp_pkg::MAX_TEXT) begin
      stored_text[stored_len] = sym;
      stored_len++;
    end
    if (eot) predict_table();
    @(negedge clk);
  endtask

  // Withdraw the offer when no byte follows
  task automatic release_input();
    text_in.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_text(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_symbol(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic random_text(input int len, input int alpha);
    logic [7:0] t[$];
    int base;
    base = $urandom_range(0, 255 - alpha);
    repeat (len) t = {t, 8'(alpha >= 255 ? $urandom_range(0, 255)
                                         : base + $urandom_range(0, alpha))};
    send_text(t);
  endtask

  // Receiver: random stalls, long hold-off when asked
  initial begin
    result_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_out.ready <= !hold_off && ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Check each result transaction against the oldest expected entry
  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected entry", result_out.suffix_start, -1);
      end else begin
        entry_t e;
        e = expected_entries.pop_front();
        if (result_out.suffix_start !== e.suffix_start)
          report_mismatch("suffix_start", result_out.suffix_start, e.suffix_start);
        if (result_out.common_prefix !== e.common_prefix)
          report_mismatch("common_prefix", result_out.common_prefix, e.common_prefix);
        if (result_out.final_entry !== e.final_entry)
          report_mismatch("final_entry", result_out.final_entry, e.final_entry);
      end
    end
  end

  task automatic test_directed();
    logic [7:0] t[$];
    t = {8'h00}; send_text(t);
    t = {8'hff}; send_text(t);
    t = {8'h00, 8'h00, 8'h00, 8'h00}; send_text(t);
    t = {8'hff, 8'h00, 8'hff, 8'h00, 8'hff}; send_text(t);
    t = {8'h62, 8'h61, 8'h6e, 8'h61, 8'h6e, 8'h61}; send_text(t);
    t = {8'h55, 8'haa, 8'h01, 8'h80, 8'h7f}; send_text(t);
    // overlong: 63 stored bytes then extras dropped
    t = {};
    repeat (66) t = {t, 8'(8'h61 + $urandom_range(0, 1))};
    send_text(t);
  endtask

  task automatic test_random(input int texts);
    repeat (texts) begin
      case ($urandom_range(0, 9))
        0:       random_text(63, $urandom_range(0, 255));
        1, 2:    random_text($urandom_range(1, 4), 255);
        default: random_text($urandom_range(1, 10), $urandom_range(0, 3));
      endcase
    end
  endtask

  // Stall the result side for a long count while texts keep coming
  task automatic test_hold_off();
    int cycles;
    hold_off = 1'b1;
    fork
      begin
        random_text(3, 2);
        random_text(4, 1);
        release_input();
      end
      begin
        cycles = 0;
        while (cycles < 3000) begin
          @(posedge clk);
          cycles++;
        end
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    release_input();
    while (expected_entries.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    text_in.valid       = 1'b0;
    text_in.symbol      = '0;
    text_in.end_of_text = 1'b0;
    mismatches = 0;
    stored_len = 0;
    hold_off = 1'b0;
    send_idle_pct = 10;
    take_idle_pct = 73;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(3);
    send_idle_pct = 73;
    take_idle_pct = 10;
    test_random(3);
    test_hold_off();
    send_idle_pct = 0;
    take_idle_pct = 0;
    test_random(3);
    drain();

    if (mismatches == 0 && expected_entries.size() == 0) begin
      $display("suffix_array_with_lcp_test OK");
    end else begin
      $display("suffix_array_with_lcp_test NOT OK");
    end
    $finish;
  end

endmodule
